### sv/lts_pkg.sv
// Shared types, status codes and the reciprocal table for the Taylor-series logarithm core.
// No dependencies; lts_div and log_taylor_series_fixed_core import this package.
package lts_pkg;

	localparam int MAX_TERMS  = 64;
	localparam int TERM_W     = 7;
	localparam int TERM_IDX_W = 6;
	localparam int ACC_W      = 40;

	localparam logic [TERM_W-1:0] TERM_COUNT_RESET = 7'd16;
	localparam logic [TERM_W-1:0] TERM_COUNT_MAX   = 7'd64;
	localparam logic [31:0]       ONE_Q16          = 32'h0001_0000;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NEG_INF = 2'd1,
		ST_INVALID = 2'd2
	} lts_status_t;

	// Status of the iterative divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} lts_div_stat_t;

	// floor(2^32 / i) for i = 1 .. 64, indexed by i - 1; the first entry is 2^32 - 1.
	localparam logic [31:0] RECIP_TABLE [MAX_TERMS] = '{
		32'hFFFFFFFF, 32'h80000000, 32'h55555555, 32'h40000000,
		32'h33333333, 32'h2AAAAAAA, 32'h24924924, 32'h20000000,
		32'h1C71C71C, 32'h19999999, 32'h1745D174, 32'h15555555,
		32'h13B13B13, 32'h12492492, 32'h11111111, 32'h10000000,
		32'h0F0F0F0F, 32'h0E38E38E, 32'h0D79435E, 32'h0CCCCCCC,
		32'h0C30C30C, 32'h0BA2E8BA, 32'h0B21642C, 32'h0AAAAAAA,
		32'h0A3D70A3, 32'h09D89D89, 32'h097B425E, 32'h09249249,
		32'h08D3DCB0, 32'h08888888, 32'h08421084, 32'h08000000,
		32'h07C1F07C, 32'h07878787, 32'h07507507, 32'h071C71C7,
		32'h06EB3E45, 32'h06BCA1AF, 32'h06906906, 32'h06666666,
		32'h063E7063, 32'h06186186, 32'h05F417D0, 32'h05D1745D,
		32'h05B05B05, 32'h0590B216, 32'h0572620A, 32'h05555555,
		32'h05397829, 32'h051EB851, 32'h05050505, 32'h04EC4EC4,
		32'h04D4873E, 32'h04BDA12F, 32'h04A7904A, 32'h04924924,
		32'h047DC11F, 32'h0469EE58, 32'h0456C797, 32'h04444444,
		32'h04325C53, 32'h04210842, 32'h04104104, 32'h04000000
	};

	function automatic logic [31:0] lts_recip(input logic [TERM_IDX_W-1:0] idx);
		return RECIP_TABLE[idx];
	endfunction

endpackage

### sv/lts_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// Depends on nothing; used by the sequencer in log_taylor_series_fixed_core.
module lts_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 64'(a) * 64'(b);
		end
	end

	assign prod = prod_q;

endmodule

### sv/lts_div.sv
// Restoring shift-subtract divider giving floor(numer * 2^32 / denom), one bit a cycle.
// Requires numer < denom. Depends on lts_pkg for the status struct.
module lts_div import lts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   numer,
	input  logic [31:0]   denom,
	output logic [31:0]   quot,
	output lts_div_stat_t stat
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [31:0] quot_q;

	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        ge;

	assign rem_sh = {rem_q, 1'b0};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so it always fits in 32 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[31:0] : rem_sh[31:0];
			quot_q <= {quot_q[30:0], ge};
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### sv/log_taylor_series_fixed_core.sv
// Natural logarithm by truncated Taylor series: Q15.16 in, Q7.24 out with a status code.
// With N terms: x>=1 runs the divider before the term loop, 0<x<1 enters it directly,
// and zero, negative x or N=0 go straight to the result. The term loop runs on one
// shared 32x32 multiplier. One transaction is in flight; the next is taken once the result
// sits in the output register. Reset clears all control state and sets term_count to 16.
module log_taylor_series_fixed_core import lts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TERM_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [31:0] x_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [31:0] log_value,
	output logic [1:0]        status
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_MULP = 7'b0000100,
		S_MULQ = 7'b0001000,
		S_MULC = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [TERM_W-1:0] term_count_q;
	logic [TERM_W-1:0] n_q;
	logic [TERM_W-1:0] i_q;
	logic              first_q;
	logic              below_q;
	lts_status_t       stat_q;
	logic [31:0]       r_q;
	logic [31:0]       p_q;
	logic [31:0]       q0_q;
	logic [ACC_W-1:0]  acc_q;
	logic              out_valid_q;
	logic [31:0]       log_value_q;
	lts_status_t       status_q;

	logic              accept;
	logic [31:0]       raw;
	logic              is_zero;
	logic              is_neg;
	logic              is_below;
	logic [TERM_W-1:0] n_clamped;
	logic [15:0]       r_below;

	logic              div_start;
	logic [31:0]       div_quot;
	lts_div_stat_t     div_stat;

	logic              mul_en;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;
	logic [31:0]       p_new;

	logic [31:0]       rem;
	logic              bump;
	logic [31:0]       term;
	logic [ACC_W:0]    rnd;
	logic [32:0]       q_mag;
	logic [31:0]       fin_value;
	logic              out_free;

	assign raw       = x_value;
	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign is_zero   = (raw == 32'h0);
	assign is_neg    = raw[31];
	assign is_below  = (raw < ONE_Q16);
	assign n_clamped = (term_count_q > TERM_COUNT_MAX) ? TERM_COUNT_MAX : term_count_q;
	assign r_below   = 16'(ONE_Q16[16:0] - raw[16:0]);
	assign div_start = accept && !is_zero && !is_neg && !is_below && (n_clamped != '0);
	assign out_free  = !out_valid_q || out_ready;

	lts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (raw - ONE_Q16),
		.denom  (raw),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	lts_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// The first power is r itself, taken straight from r_q while first_q is set.
	assign p_new = first_q ? r_q : prod[63:32];

	always_comb begin
		mul_en = 1'b0;
		mul_a  = p_q;
		mul_b  = r_q;
		unique case (state_q)
			S_MULP: begin
				mul_en = 1'b1;
			end
			S_MULQ: begin
				mul_en = 1'b1;
				mul_a  = p_new;
				mul_b  = lts_recip(TERM_IDX_W'(i_q - 7'd1));
			end
			S_MULC: begin
				mul_en = 1'b1;
				mul_a  = prod[63:32];
				mul_b  = 32'(i_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// The reciprocal estimate is at most one short, so one compare corrects the quotient.
	assign rem  = p_q - prod[31:0];
	assign bump = (rem >= 32'(i_q));
	assign term = q0_q + 32'(bump);

	assign rnd   = {1'b0, acc_q} + (ACC_W+1)'(128);
	assign q_mag = rnd[40:8];

	always_comb begin
		if (stat_q != ST_OK) begin
			fin_value = 32'h0;
		end else if (below_q) begin
			fin_value = (q_mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'h0 - q_mag);
		end else begin
			fin_value = (q_mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_mag[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			term_count_q <= TERM_COUNT_RESET;
			out_valid_q  <= 1'b0;
			first_q      <= 1'b0;
			i_q          <= '0;
			n_q          <= '0;
		end else begin
			if (cfg_we) begin
				term_count_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= n_clamped;
						i_q     <= 7'd1;
						first_q <= 1'b1;
						if (is_zero || is_neg || (n_clamped == '0)) begin
							state_q <= S_FIN;
						end else if (is_below) begin
							state_q <= S_MULQ;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_MULQ;
					end
				end
				S_MULP: begin
					state_q <= S_MULQ;
				end
				S_MULQ: begin
					first_q <= 1'b0;
					state_q <= S_MULC;
				end
				S_MULC: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (i_q == n_q) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_MULP;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= '0;
			below_q <= is_below;
			r_q     <= {r_below, 16'h0};
			if (is_zero) begin
				stat_q <= ST_NEG_INF;
			end else if (is_neg) begin
				stat_q <= ST_INVALID;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (state_q == S_DIV && div_stat.done) begin
			r_q <= div_quot;
		end
		if (state_q == S_MULQ) begin
			p_q <= p_new;
		end
		if (state_q == S_MULC) begin
			q0_q <= prod[63:32];
		end
		if (state_q == S_ACC) begin
			acc_q <= acc_q + ACC_W'(term);
		end
		if (state_q == S_FIN && out_free) begin
			log_value_q <= fin_value;
			status_q    <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign log_value = log_value_q;
	assign status    = status_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_stat.busy)
		else $error("divider busy while the core is idle");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide phase");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (i_q >= 7'd1 && i_q <= n_q && n_q <= TERM_COUNT_MAX))
		else $error("term index out of range");

	a_recip_error: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (rem < {24'h0, i_q, 1'b0}))
		else $error("reciprocal quotient off by more than one");

	a_special_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (is_zero || is_neg)) |=> (state_q == S_FIN && stat_q != ST_OK))
		else $error("special argument did not go straight to the result");

endmodule
